// ----- rtl/sbh_pkg.sv -----
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared types, codes and helpers for the serial bootloader host engine.
// ----------------------------------------------------------------------------
package sbh_pkg;

    localparam int MaxBlock  = 256;
    localparam int MaxRes    = 6;

    localparam logic [7:0] ACK_BYTE  = 8'h79;
    localparam logic [7:0] NACK_BYTE = 8'h1F;

    localparam logic [1:0] F_TICK    = 2'd0;
    localparam logic [1:0] F_RXBYTE  = 2'd1;
    localparam logic [1:0] F_START   = 2'd2;
    localparam logic [1:0] F_PAYLOAD = 2'd3;

    localparam logic [2:0] OP_SYNC  = 3'd0;
    localparam logic [2:0] OP_GETID = 3'd1;
    localparam logic [2:0] OP_ERASE = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_GO    = 3'd5;

    localparam logic [1:0] K_TX   = 2'd0;
    localparam logic [1:0] K_DATA = 2'd1;
    localparam logic [1:0] K_FIN  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NACK    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_BADLEN  = 2'd3;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_ERASE   = 2'd1;
    localparam logic [1:0] REG_IDBYTE  = 2'd2;

    typedef enum logic [10:0] {
        PH_IDLE      = 11'b00000000001,
        PH_ACK_CMD   = 11'b00000000010,
        PH_ACK_ADDR  = 11'b00000000100,
        PH_ACK_ERASE = 11'b00000001000,
        PH_ACK_BLOCK = 11'b00000010000,
        PH_ACK_READN = 11'b00000100000,
        PH_ACK_ID    = 11'b00001000000,
        PH_ID_LEN    = 11'b00010000000,
        PH_ID_DATA   = 11'b00100000000,
        PH_PAYLOAD   = 11'b01000000000,
        PH_READ_DATA = 11'b10000000000
    } sbh_phase_t;

    typedef struct packed {
        logic [15:0] timeout;
        logic [15:0] erase_timeout;
        logic [15:0] id_timeout;
    } sbh_cfg_t;

    typedef struct packed {
        logic [2:0]                n;
        logic [MaxRes-1:0][1:0]    kind;
        logic [MaxRes-1:0][7:0]    data;
        logic [1:0]                status;
        logic [15:0]               chip_id;
    } sbh_desc_t;

    function automatic logic [7:0] cmd_code(input logic [2:0] op);
        logic [7:0] c;
        case (op)
            OP_SYNC:  c = 8'h7F;
            OP_GETID: c = 8'h02;
            OP_ERASE: c = 8'h44;
            OP_WRITE: c = 8'h31;
            OP_READ:  c = 8'h11;
            default:  c = 8'h21;
        endcase
        return c;
    endfunction

    function automatic sbh_desc_t push(input sbh_desc_t d, input logic [1:0] k,
                                       input logic [7:0] b);
        sbh_desc_t r;
        r = d;
        r.kind[d.n] = k;
        r.data[d.n] = b;
        r.n = d.n + 3'd1;
        return r;
    endfunction

endpackage

// ----- rtl/serial_bootloader_host_engine.sv -----
// ----------------------------------------------------------------------------
// serial_bootloader_host_engine
// Host side of a serial bootloader link: runs sync, get ID, erase, write,
// read and go operations and streams out the bytes and results.
//
// Channel  Dir  tdata (low bit up)                         tuser  tlast
// s_axis   in   op, target_addr, length, in_byte           func   -
// m_axis   out  out_byte, status, chip_id                  kind   last
// apb      in   timeout, erase timeout, id byte timeout    -      -
//
// The front takes one item per cycle while the queue has room.
// Each item yields 0 to 5 results, sent one per cycle by the back part while the
// output is ready; the drain of those results sets the sustained rate.
// Reset sets idle phase and the default wait limits; there is no clear pass.
// Output stalls hold the head descriptor; the front stalls when both
// queue entries are occupied.
// ----------------------------------------------------------------------------
module serial_bootloader_host_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // op, target_addr, length, in_byte, zero pad
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte, status, chip_id, zero pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sbh_pkg::*;

    sbh_cfg_t    cfg_reg;
    sbh_desc_t   push_desc;
    sbh_desc_t   head;
    logic        push_valid;
    logic        full;
    logic        not_empty;
    logic        pop;
    logic        in_acc;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [15:0] chip_id;

    assign pready   = 1'b1;
    assign s_tready = !full;
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout       <= 16'd1000;
            cfg_reg.erase_timeout <= 16'd8000;
            cfg_reg.id_timeout    <= 16'd300;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_TIMEOUT: cfg_reg.timeout       <= pwdata[15:0];
                REG_ERASE:   cfg_reg.erase_timeout <= pwdata[15:0];
                REG_IDBYTE:  cfg_reg.id_timeout    <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TIMEOUT: prdata = {16'h0000, cfg_reg.timeout};
            REG_ERASE:   prdata = {16'h0000, cfg_reg.erase_timeout};
            REG_IDBYTE:  prdata = {16'h0000, cfg_reg.id_timeout};
            default:     prdata = '0;
        endcase
    end

    sbh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_acc),
        .func        (s_tuser),
        .op          (s_tdata[2:0]),
        .target_addr (s_tdata[34:3]),
        .length      (s_tdata[43:35]),
        .in_byte     (s_tdata[51:44]),
        .push_valid  (push_valid),
        .push_desc   (push_desc)
    );

    sbh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    sbh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .kind       (m_tuser),
        .out_byte   (out_byte),
        .status     (status),
        .chip_id    (chip_id),
        .last       (m_tlast)
    );

    assign m_tdata = {6'b000000, chip_id, status, out_byte};

endmodule

// ----- rtl/sbh_front.sv -----
// ----------------------------------------------------------------------------
// sbh_front
// Accepts input items, runs the protocol state and builds one result
// descriptor per item that yields results; items with none push nothing.
// ----------------------------------------------------------------------------
module sbh_front (
    input  logic              clk,
    input  logic              rst_n,
    input  sbh_pkg::sbh_cfg_t cfg,
    input  logic              in_valid,
    input  logic [1:0]        func,
    input  logic [2:0]        op,
    input  logic [31:0]       target_addr,
    input  logic [8:0]        length,
    input  logic [7:0]        in_byte,
    output logic              push_valid,
    output sbh_pkg::sbh_desc_t push_desc
);
    import sbh_pkg::*;

    sbh_phase_t  phase_reg, phase_next;
    logic [2:0]  op_reg, op_next;
    logic [31:0] addr_reg, addr_next;
    logic [8:0]  count_reg, count_next;
    logic [8:0]  idx_reg, idx_next;
    logic [7:0]  xor_reg, xor_next;
    logic [16:0] wait_reg, wait_next;
    logic [8:0]  idrem_reg, idrem_next;
    logic [15:0] idhold_reg, idhold_next;

    always_comb
    begin
        sbh_desc_t  d;
        logic [7:0] n8;
        logic [7:0] ax;
        d = '0;
        n8 = 8'(count_reg - 9'd1);
        ax = addr_reg[31:24] ^ addr_reg[23:16] ^ addr_reg[15:8] ^ addr_reg[7:0];
        phase_next = phase_reg;
        op_next = op_reg;
        addr_next = addr_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        xor_next = xor_reg;
        wait_next = wait_reg;
        idrem_next = idrem_reg;
        idhold_next = idhold_reg;
        case (func)
            F_TICK:
            begin
                if (phase_reg != PH_IDLE && phase_reg != PH_PAYLOAD)
                begin
                    if (wait_reg <= 17'd1)
                    begin
                        wait_next = '0;
                        d = push(d, K_FIN, 8'h00);
                        d.status = ST_TIMEOUT;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        wait_next = wait_reg - 17'd1;
                    end
                end
            end
            F_RXBYTE:
            begin
                unique case (phase_reg)
                    PH_ACK_CMD, PH_ACK_ADDR, PH_ACK_ERASE, PH_ACK_BLOCK,
                    PH_ACK_READN, PH_ACK_ID:
                    begin
                        if (in_byte == NACK_BYTE)
                        begin
                            d = push(d, K_FIN, 8'h00);
                            d.status = ST_NACK;
                            phase_next = PH_IDLE;
                        end
                        else if (in_byte == ACK_BYTE)
                        begin
                            if (phase_reg == PH_ACK_CMD)
                            begin
                                if (op_reg == OP_SYNC)
                                begin
                                    d = push(d, K_FIN, 8'h00);
                                    phase_next = PH_IDLE;
                                end
                                else if (op_reg == OP_GETID)
                                begin
                                    phase_next = PH_ID_LEN;
                                    wait_next = {1'b0, cfg.id_timeout};
                                end
                                else if (op_reg == OP_ERASE)
                                begin
                                    d = push(d, K_TX, 8'hFF);
                                    d = push(d, K_TX, 8'hFF);
                                    d = push(d, K_TX, 8'h00);
                                    phase_next = PH_ACK_ERASE;
                                    wait_next = {1'b0, cfg.erase_timeout};
                                end
                                else
                                begin
                                    d = push(d, K_TX, addr_reg[31:24]);
                                    d = push(d, K_TX, addr_reg[23:16]);
                                    d = push(d, K_TX, addr_reg[15:8]);
                                    d = push(d, K_TX, addr_reg[7:0]);
                                    d = push(d, K_TX, ax);
                                    phase_next = PH_ACK_ADDR;
                                    wait_next = {1'b0, cfg.timeout};
                                end
                            end
                            else if (phase_reg == PH_ACK_ADDR)
                            begin
                                if (op_reg == OP_WRITE)
                                begin
                                    d = push(d, K_TX, n8);
                                    xor_next = n8;
                                    idx_next = '0;
                                    phase_next = PH_PAYLOAD;
                                end
                                else if (op_reg == OP_READ)
                                begin
                                    d = push(d, K_TX, n8);
                                    d = push(d, K_TX, ~n8);
                                    phase_next = PH_ACK_READN;
                                    wait_next = {1'b0, cfg.timeout};
                                end
                                else
                                begin
                                    d = push(d, K_FIN, 8'h00);
                                    phase_next = PH_IDLE;
                                end
                            end
                            else if (phase_reg == PH_ACK_READN)
                            begin
                                idx_next = '0;
                                phase_next = PH_READ_DATA;
                                wait_next = {1'b0, cfg.timeout};
                            end
                            else
                            begin
                                d = push(d, K_FIN, 8'h00);
                                if (op_reg == OP_GETID)
                                begin
                                    d.chip_id = idhold_reg;
                                end
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_ID_LEN:
                    begin
                        idrem_next = {1'b0, in_byte} + 9'd1;
                        idx_next = '0;
                        phase_next = PH_ID_DATA;
                        wait_next = {1'b0, cfg.id_timeout};
                    end
                    PH_ID_DATA:
                    begin
                        if (idx_reg == 9'd0)
                        begin
                            idhold_next = {in_byte, idhold_reg[7:0]};
                        end
                        else if (idx_reg == 9'd1)
                        begin
                            idhold_next = {idhold_reg[15:8], in_byte};
                        end
                        if (idx_reg != 9'd511)
                        begin
                            idx_next = idx_reg + 9'd1;
                        end
                        idrem_next = idrem_reg - 9'd1;
                        if (idrem_reg == 9'd1)
                        begin
                            phase_next = PH_ACK_ID;
                            wait_next = {1'b0, cfg.timeout};
                        end
                        else
                        begin
                            wait_next = {1'b0, cfg.id_timeout};
                        end
                    end
                    PH_READ_DATA:
                    begin
                        d = push(d, K_DATA, in_byte);
                        idx_next = idx_reg + 9'd1;
                        if (idx_reg + 9'd1 >= count_reg)
                        begin
                            d = push(d, K_FIN, 8'h00);
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            F_START:
            begin
                if (phase_reg == PH_IDLE && op <= OP_GO)
                begin
                    op_next = op;
                    addr_next = target_addr;
                    count_next = length;
                    idx_next = '0;
                    xor_next = '0;
                    if ((op == OP_WRITE || op == OP_READ) &&
                        (length == 9'd0 || 32'(length) > MaxBlock))
                    begin
                        d = push(d, K_FIN, 8'h00);
                        d.status = ST_BADLEN;
                    end
                    else
                    begin
                        if (op == OP_GETID)
                        begin
                            idhold_next = '0;
                            idrem_next = '0;
                        end
                        d = push(d, K_TX, cmd_code(op));
                        if (op != OP_SYNC)
                        begin
                            d = push(d, K_TX, ~cmd_code(op));
                        end
                        phase_next = PH_ACK_CMD;
                        wait_next = {1'b0, cfg.timeout};
                    end
                end
            end
            default:
            begin
                if (phase_reg == PH_PAYLOAD)
                begin
                    d = push(d, K_TX, in_byte);
                    xor_next = xor_reg ^ in_byte;
                    idx_next = idx_reg + 9'd1;
                    if (idx_reg + 9'd1 >= count_reg)
                    begin
                        d = push(d, K_TX, xor_reg ^ in_byte);
                        phase_next = PH_ACK_BLOCK;
                        wait_next = {cfg.timeout, 1'b0};
                    end
                end
            end
        endcase
        push_desc = d;
    end

    assign push_valid = in_valid && (push_desc.n != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            op_reg     <= '0;
            addr_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            xor_reg    <= '0;
            wait_reg   <= '0;
            idrem_reg  <= '0;
            idhold_reg <= '0;
        end
        else if (in_valid)
        begin
            phase_reg  <= phase_next;
            op_reg     <= op_next;
            addr_reg   <= addr_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            xor_reg    <= xor_next;
            wait_reg   <= wait_next;
            idrem_reg  <= idrem_next;
            idhold_reg <= idhold_next;
        end
    end

endmodule

// ----- rtl/sbh_queue.sv -----
// ----------------------------------------------------------------------------
// sbh_queue
// Two-entry descriptor queue between the front and back parts.
// ----------------------------------------------------------------------------
module sbh_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sbh_pkg::sbh_desc_t push_desc,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output sbh_pkg::sbh_desc_t head
);
    import sbh_pkg::*;

    sbh_desc_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty)) else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");

endmodule

// ----- rtl/sbh_back.sv -----
// ----------------------------------------------------------------------------
// sbh_back
// Walks the head descriptor and presents its result items one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module sbh_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  sbh_pkg::sbh_desc_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [7:0]         out_byte,
    output logic [1:0]         status,
    output logic [15:0]        chip_id,
    output logic               last
);
    import sbh_pkg::*;

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       is_fin;

    assign out_valid = head_valid;
    assign kind      = head.kind[idx_reg];
    assign out_byte  = head.data[idx_reg];
    assign is_fin    = (kind == K_FIN);
    assign status    = is_fin ? head.status : ST_OK;
    assign chip_id   = is_fin ? head.chip_id : 16'h0000;
    assign last      = (idx_reg + 3'd1 == head.n);
    assign pop       = out_valid && out_ready && last;
    assign idx_next  = pop ? 3'd0 : idx_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial bootloader host engine. Builds whole
// bootloader conversations (start, acknowledges, identifier reply, payload,
// read data) mixed with stray bytes, ticks and broken sequences. A request
// driven model of the link protocol predicts every streamed result, and the
// results are compared in order under several wait limits and flow patterns.
// ----------------------------------------------------------------------------
module tb;
    import sbh_pkg::*;

    localparam int LIMIT = 1000000;
    localparam int SETTLE = 20;

    typedef struct {
        logic [1:0]  func;
        logic [2:0]  op;
        logic [31:0] addr;
        logic [8:0]  len;
        logic [7:0]  b;
    } req_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  ob;
        logic [1:0]  st;
        logic [15:0] cid;
        logic        lst;
    } res_t;

    typedef enum logic [3:0] {
        L_IDLE, L_ACK_CMD, L_ACK_ADDR, L_ACK_ERASE, L_ACK_BLOCK, L_ACK_READN,
        L_ACK_ID, L_ID_LEN, L_ID_DATA, L_PAYLOAD, L_READ_DATA
    } link_phase_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    req_t        pending_reqs[$];
    res_t        expected_results[$];
    res_t        step_results[$];
    int          errors;
    int          gen_count;
    int          send_gap;
    int          recv_stall;
    int          cycles;

    logic [15:0] lim_ack;
    logic [15:0] lim_erase;
    logic [15:0] lim_id;
    link_phase_t lph;
    logic [2:0]  cur_op;
    logic [31:0] cur_addr;
    logic [8:0]  blk_len;
    logic [8:0]  idx;
    logic [7:0]  csum;
    logic [16:0] ticks_left;
    logic [8:0]  id_left;
    logic [15:0] id_word;

    serial_bootloader_host_engine i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] op_code(input logic [2:0] op);
        case (op)
            OP_SYNC:  return 8'h7F;
            OP_GETID: return 8'h02;
            OP_ERASE: return 8'h44;
            OP_WRITE: return 8'h31;
            OP_READ:  return 8'h11;
            default:  return 8'h21;
        endcase
    endfunction

    task automatic emit(input logic [1:0] k, input logic [7:0] ob, input logic [1:0] st,
                        input logic [15:0] cid);
        res_t r;
        r.kind = k;
        r.ob = ob;
        r.st = st;
        r.cid = cid;
        r.lst = 1'b0;
        if (step_results.size() < MaxRes)
            step_results.push_back(r);
    endtask

    task automatic finish_op(input logic [1:0] st);
        emit(K_FIN, 8'h00, st, (st == ST_OK && cur_op == OP_GETID) ? id_word : 16'h0);
        lph = L_IDLE;
    endtask

    task automatic arm(input link_phase_t p, input logic [16:0] t);
        lph = p;
        ticks_left = t;
    endtask

    task automatic on_ack();
        logic [7:0] n;
        logic [7:0] a0, a1, a2, a3;
        n = 8'(blk_len - 9'd1);
        case (lph)
            L_ACK_CMD:
                if (cur_op == OP_SYNC)
                    finish_op(ST_OK);
                else if (cur_op == OP_GETID)
                    arm(L_ID_LEN, {1'b0, lim_id});
                else if (cur_op == OP_ERASE)
                begin
                    emit(K_TX, 8'hFF, ST_OK, 16'h0);
                    emit(K_TX, 8'hFF, ST_OK, 16'h0);
                    emit(K_TX, 8'h00, ST_OK, 16'h0);
                    arm(L_ACK_ERASE, {1'b0, lim_erase});
                end
                else
                begin
                    a0 = cur_addr[31:24];
                    a1 = cur_addr[23:16];
                    a2 = cur_addr[15:8];
                    a3 = cur_addr[7:0];
                    emit(K_TX, a0, ST_OK, 16'h0);
                    emit(K_TX, a1, ST_OK, 16'h0);
                    emit(K_TX, a2, ST_OK, 16'h0);
                    emit(K_TX, a3, ST_OK, 16'h0);
                    emit(K_TX, a0 ^ a1 ^ a2 ^ a3, ST_OK, 16'h0);
                    arm(L_ACK_ADDR, {1'b0, lim_ack});
                end
            L_ACK_ADDR:
                if (cur_op == OP_WRITE)
                begin
                    emit(K_TX, n, ST_OK, 16'h0);
                    csum = n;
                    idx = '0;
                    lph = L_PAYLOAD;
                end
                else if (cur_op == OP_READ)
                begin
                    emit(K_TX, n, ST_OK, 16'h0);
                    emit(K_TX, ~n, ST_OK, 16'h0);
                    arm(L_ACK_READN, {1'b0, lim_ack});
                end
                else
                    finish_op(ST_OK);
            L_ACK_READN:
            begin
                idx = '0;
                arm(L_READ_DATA, {1'b0, lim_ack});
            end
            default:
                finish_op(ST_OK);
        endcase
    endtask

    task automatic predict_request(input req_t q);
        step_results.delete();
        case (q.func)
            F_TICK:
                if (lph != L_IDLE && lph != L_PAYLOAD)
                begin
                    if (ticks_left <= 17'd1)
                    begin
                        ticks_left = '0;
                        finish_op(ST_TIMEOUT);
                    end
                    else
                        ticks_left = ticks_left - 17'd1;
                end
            F_RXBYTE:
                if (lph >= L_ACK_CMD && lph <= L_ACK_ID)
                begin
                    if (q.b == ACK_BYTE)
                        on_ack();
                    else if (q.b == NACK_BYTE)
                        finish_op(ST_NACK);
                end
                else if (lph == L_ID_LEN)
                begin
                    id_left = {1'b0, q.b} + 9'd1;
                    idx = '0;
                    arm(L_ID_DATA, {1'b0, lim_id});
                end
                else if (lph == L_ID_DATA)
                begin
                    if (idx == 9'd0)
                        id_word[15:8] = q.b;
                    else if (idx == 9'd1)
                        id_word[7:0] = q.b;
                    if (idx < 9'd511)
                        idx = idx + 9'd1;
                    id_left = id_left - 9'd1;
                    if (id_left == 9'd0)
                        arm(L_ACK_ID, {1'b0, lim_ack});
                    else
                        arm(L_ID_DATA, {1'b0, lim_id});
                end
                else if (lph == L_READ_DATA)
                begin
                    emit(K_DATA, q.b, ST_OK, 16'h0);
                    idx = idx + 9'd1;
                    if (idx >= blk_len)
                        finish_op(ST_OK);
                end
            F_START:
                if (lph == L_IDLE && q.op <= OP_GO)
                begin
                    cur_op = q.op;
                    cur_addr = q.addr;
                    blk_len = q.len;
                    idx = '0;
                    csum = '0;
                    if ((q.op == OP_WRITE || q.op == OP_READ) &&
                        (q.len == 9'd0 || q.len > MaxBlock))
                        emit(K_FIN, 8'h00, ST_BADLEN, 16'h0);
                    else
                    begin
                        if (q.op == OP_GETID)
                        begin
                            id_word = '0;
                            id_left = '0;
                        end
                        emit(K_TX, op_code(q.op), ST_OK, 16'h0);
                        if (q.op != OP_SYNC)
                            emit(K_TX, ~op_code(q.op), ST_OK, 16'h0);
                        arm(L_ACK_CMD, {1'b0, lim_ack});
                    end
                end
            default:
                if (lph == L_PAYLOAD)
                begin
                    emit(K_TX, q.b, ST_OK, 16'h0);
                    csum = csum ^ q.b;
                    idx = idx + 9'd1;
                    if (idx >= blk_len)
                    begin
                        emit(K_TX, csum, ST_OK, 16'h0);
                        arm(L_ACK_BLOCK, {lim_ack, 1'b0});
                    end
                end
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].lst = 1'b1;
        foreach (step_results[i])
            expected_results.push_back(step_results[i]);
    endtask

    always @(posedge clk)
    begin
        if (!s_tvalid || s_tready)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_gap)
            begin
                req_t q;
                q = pending_reqs.pop_front();
                predict_request(q);
                s_tvalid <= 1'b1;
                s_tdata <= {4'h0, q.b, q.len, q.addr, q.op};
                s_tuser <= q.func;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t: unexpected result kind=%0d data=%h last=%b", $time,
                         m_tuser, m_tdata, m_tlast);
            end
            else
            begin
                res_t e;
                e = expected_results.pop_front();
                if (m_tuser !== e.kind || m_tdata[7:0] !== e.ob || m_tdata[9:8] !== e.st ||
                    m_tdata[25:10] !== e.cid || m_tlast !== e.lst)
                begin
                    errors = errors + 1;
                    $display("%0t: expected kind=%0d byte=%h st=%0d id=%h last=%b",
                             $time, e.kind, e.ob, e.st, e.cid, e.lst);
                    $display("%0t: actual   kind=%0d byte=%h st=%0d id=%h last=%b",
                             $time, m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[25:10],
                             m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_req(input logic [1:0] f, input logic [2:0] op, input logic [31:0] a,
                            input logic [8:0] len, input logic [7:0] b);
        req_t q;
        q.func = f;
        q.op = op;
        q.addr = a;
        q.len = len;
        q.b = b;
        pending_reqs.push_back(q);
        gen_count = gen_count + 1;
    endtask

    task automatic push_rx(input logic [7:0] b);
        push_req(F_RXBYTE, 3'($urandom), $urandom, 9'($urandom), b);
    endtask

    task automatic push_tick();
        push_req(F_TICK, 3'($urandom), $urandom, 9'($urandom), 8'($urandom));
    endtask

    task automatic push_ack();
        int r;
        logic [7:0] junk;
        r = $urandom_range(99);
        if (r < 12)
        begin
            junk = 8'($urandom);
            if (junk == ACK_BYTE || junk == NACK_BYTE)
                junk = 8'h00;
            push_rx(junk);
        end
        else if (r < 24)
            repeat ($urandom_range(3, 1)) push_tick();
        if ($urandom_range(99) < 5)
            push_rx(NACK_BYTE);
        else
            push_rx(ACK_BYTE);
    endtask

    task automatic push_session();
        logic [2:0] op;
        logic [8:0] len;
        int n;
        op = 3'($urandom_range(5));
        len = 9'($urandom_range(8, 1));
        if ($urandom_range(29) == 0)
            len = ($urandom_range(1) == 0) ? 9'd0 : 9'($urandom_range(511, 257));
        push_req(F_START, op, $urandom, len, 8'($urandom));
        push_ack();
        case (op)
            OP_GETID:
            begin
                n = $urandom_range(3);
                push_rx(8'(n));
                repeat (n + 1) push_rx(8'($urandom));
                push_ack();
            end
            OP_ERASE, OP_GO:
                push_ack();
            OP_WRITE:
            begin
                push_ack();
                if (len <= MaxBlock)
                    repeat (len) push_req(F_PAYLOAD, 3'($urandom), $urandom, 9'($urandom),
                                          8'($urandom));
                push_ack();
            end
            OP_READ:
            begin
                push_ack();
                push_ack();
                if (len <= MaxBlock)
                    repeat (len) push_rx(8'($urandom));
            end
            default: ;
        endcase
    endtask

    task automatic push_noise();
        push_req(2'($urandom), 3'($urandom), $urandom, 9'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx_reg, input logic [15:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx_reg, 2'b00};
        pwdata <= {16'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx_reg)
            REG_TIMEOUT: lim_ack = v;
            REG_ERASE:   lim_erase = v;
            default:     lim_id = v;
        endcase
    endtask

    task automatic run_phase(input logic [15:0] t0, input logic [15:0] t1,
                             input logic [15:0] t2, input int gap, input int stall,
                             input int count);
        int start;
        apb_write(REG_TIMEOUT, t0);
        apb_write(REG_ERASE, t1);
        apb_write(REG_IDBYTE, t2);
        send_gap = gap;
        recv_stall = stall;
        start = gen_count;
        while (gen_count - start < count)
        begin
            if ($urandom_range(99) < 80)
                push_session();
            else
                repeat ($urandom_range(4, 1)) push_noise();
        end
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        gen_count = 0;
        cycles = 0;
        send_gap = 0;
        recv_stall = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        lim_ack = 16'd1000;
        lim_erase = 16'd8000;
        lim_id = 16'd300;
        lph = L_IDLE;
        cur_op = '0;
        cur_addr = '0;
        blk_len = '0;
        idx = '0;
        csum = '0;
        ticks_left = '0;
        id_left = '0;
        id_word = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray requests in idle, unknown op, bad lengths
        push_tick();
        push_rx(ACK_BYTE);
        push_req(F_PAYLOAD, OP_SYNC, 32'h0, 9'd0, 8'hFF);
        push_req(F_START, 3'd7, 32'hFFFF_FFFF, 9'd511, 8'h00);
        push_req(F_START, OP_WRITE, 32'h1234_5678, 9'd0, 8'h00);
        push_req(F_START, OP_READ, 32'h0, 9'd511, 8'h00);
        push_req(F_START, OP_READ, 32'h0, 9'd257, 8'h00);
        // sync with busy start
        push_req(F_START, OP_SYNC, 32'h0, 9'd0, 8'h00);
        push_req(F_START, OP_GO, 32'h0, 9'd1, 8'h00);
        push_rx(ACK_BYTE);
        // get id, length byte zero: one id byte only
        push_req(F_START, OP_GETID, 32'h0, 9'd0, 8'h00);
        push_rx(ACK_BYTE);
        push_rx(8'h00);
        push_rx(8'hA5);
        push_rx(ACK_BYTE);
        // erase, nack
        push_req(F_START, OP_ERASE, 32'h0, 9'd0, 8'h00);
        push_rx(NACK_BYTE);
        // write one byte at top address
        push_req(F_START, OP_WRITE, 32'hFFFF_FFFF, 9'd1, 8'h00);
        push_rx(ACK_BYTE);
        push_rx(ACK_BYTE);
        push_rx(8'h55);
        push_req(F_PAYLOAD, OP_SYNC, 32'h0, 9'd0, 8'hFF);
        push_tick();
        push_rx(ACK_BYTE);
        // go at zero
        push_req(F_START, OP_GO, 32'h0000_0000, 9'd0, 8'h00);
        push_rx(ACK_BYTE);
        push_rx(ACK_BYTE);
        wait_drained();

        run_phase(16'd1000, 16'd8000, 16'd300, 0, 0, 35);
        run_phase(16'd1, 16'd1, 16'd1, 54, 0, 40);
        run_phase(16'd65535, 16'd65535, 16'd65535, 0, 54, 40);
        run_phase(16'd3, 16'd2, 16'd2, 30, 30, 40);
        run_phase(16'd2, 16'd4, 16'd3, 0, 0, 40);

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- serial_bootloader_host_engine.f -----
rtl/sbh_pkg.sv
rtl/sbh_front.sv
rtl/sbh_queue.sv
rtl/sbh_back.sv
rtl/serial_bootloader_host_engine.sv
tb/sv/tb.sv
